>>> src/iote_pkg.sv
// Shared types and constants for the IPv4 option TLV extractor.
package iote_pkg;

    localparam int MAX_CAPTURE_BYTES = 8;
    localparam int MAX_AREA_BYTES    = 40;

    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] OPT_END     = 8'd0;
    localparam logic [7:0] OPT_NOP     = 8'd1;
    localparam logic [7:0] MIN_OPT_LEN = 8'd2;

    // configuration register indexes
    localparam logic CFG_CODE = 1'b0;
    localparam logic CFG_LEN  = 1'b1;

    typedef enum logic [4:0] {
        PH_TYPE = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_SKIP = 5'b00100,
        PH_CAPT = 5'b01000,
        PH_DONE = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_CAPT   = 2'd1,
        ST_BAD    = 2'd2,
        ST_NOTUDP = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]  option_byte;
        logic [5:0]  area_length;
        logic        first_item;
        logic        last_item;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [63:0] captured_option;
        logic [31:0] packet_source_address;
        logic [31:0] packet_destination_address;
        logic [15:0] packet_source_port;
        logic [15:0] packet_destination_port;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] code;
        logic [3:0] length;
    } t_cfg;

    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_walk_res;

endpackage

>>> src/iote_walk.sv
// Option walk state and per-beat next-state logic.
module iote_walk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  iote_pkg::t_in_beat i_beat,
    input  iote_pkg::t_cfg     i_cfg,
    output iote_pkg::t_walk_res o_res
);

    iote_pkg::t_phase  r_ph,    n_ph,    c_ph;
    iote_pkg::t_status r_st,    n_st,    c_st;
    logic [5:0]        r_abl,   n_abl,   c_abl;
    logic [5:0]        r_obl,   n_obl,   c_obl;
    logic [2:0]        r_cpos,  n_cpos,  c_cpos;
    logic [63:0]       r_cap,   n_cap,   c_cap;
    logic [7:0]        r_ctype, n_ctype, c_ctype;

    logic [7:0]        b;
    logic [5:0]        alen_sat;
    logic [7:0]        left_p1;
    logic [7:0]        b_m2;
    logic [5:0]        obl_dec;
    iote_pkg::t_status fin_st;

    assign b = i_beat.option_byte;

    always_comb begin
        c_ph    = r_ph;
        c_st    = r_st;
        c_abl   = r_abl;
        c_obl   = r_obl;
        c_cpos  = r_cpos;
        c_cap   = r_cap;
        c_ctype = r_ctype;

        alen_sat = (i_beat.area_length > 6'(iote_pkg::MAX_AREA_BYTES)) ?
                   6'(iote_pkg::MAX_AREA_BYTES) : i_beat.area_length;

        if (i_beat.first_item) begin
            c_abl   = alen_sat;
            c_obl   = '0;
            c_cpos  = '0;
            c_cap   = '0;
            c_ctype = '0;
            c_st    = iote_pkg::ST_NONE;
            c_ph    = (alen_sat == '0) ? iote_pkg::PH_DONE : iote_pkg::PH_TYPE;
        end

        n_ph    = c_ph;
        n_st    = c_st;
        n_abl   = c_abl;
        n_obl   = c_obl;
        n_cpos  = c_cpos;
        n_cap   = c_cap;
        n_ctype = c_ctype;

        left_p1 = {2'b00, c_abl} + 8'd1;   // type byte was one more area byte
        b_m2    = b - iote_pkg::MIN_OPT_LEN;
        obl_dec = c_obl - 6'd1;

        if (c_abl != '0 && c_ph != iote_pkg::PH_DONE) begin
            case (c_ph)
                iote_pkg::PH_TYPE: begin
                    if (b == iote_pkg::OPT_END) begin
                        n_st = iote_pkg::ST_NONE;
                        n_ph = iote_pkg::PH_DONE;
                    end else if (b != iote_pkg::OPT_NOP) begin
                        if ({2'b00, c_abl} < iote_pkg::MIN_OPT_LEN) begin
                            n_st = iote_pkg::ST_BAD;
                            n_ph = iote_pkg::PH_DONE;
                        end else begin
                            n_ctype = b;
                            n_ph    = iote_pkg::PH_LEN;
                        end
                    end
                end
                iote_pkg::PH_LEN: begin
                    n_obl = b_m2[5:0];
                    if (b < iote_pkg::MIN_OPT_LEN || b > left_p1) begin
                        n_obl = c_obl;
                        n_st  = iote_pkg::ST_BAD;
                        n_ph  = iote_pkg::PH_DONE;
                    end else if (c_ctype == i_cfg.code && b == {4'b0000, i_cfg.length} &&
                                 b <= 8'(iote_pkg::MAX_CAPTURE_BYTES)) begin
                        n_cap  = {48'd0, b, c_ctype};
                        n_cpos = 3'd2;
                        if (b_m2[5:0] == '0) begin
                            n_st = iote_pkg::ST_CAPT;
                            n_ph = iote_pkg::PH_DONE;
                        end else begin
                            n_ph = iote_pkg::PH_CAPT;
                        end
                    end else begin
                        n_ph = (b_m2[5:0] == '0) ? iote_pkg::PH_TYPE : iote_pkg::PH_SKIP;
                    end
                end
                iote_pkg::PH_SKIP: begin
                    n_obl = obl_dec;
                    if (obl_dec == '0) begin
                        n_ph = iote_pkg::PH_TYPE;
                    end
                end
                iote_pkg::PH_CAPT: begin
                    for (int k = 0; k < 8; k++) begin
                        if (3'(k) == c_cpos) begin
                            n_cap[k*8 +: 8] = c_cap[k*8 +: 8] | b;
                        end
                    end
                    n_cpos = c_cpos + 3'd1;
                    n_obl  = obl_dec;
                    if (obl_dec == '0) begin
                        n_st = iote_pkg::ST_CAPT;
                        n_ph = iote_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase

            n_abl = c_abl - 6'd1;
            if (n_abl == '0 && n_ph == iote_pkg::PH_TYPE) begin
                n_st = iote_pkg::ST_NONE;
                n_ph = iote_pkg::PH_DONE;
            end
        end

        // a packet that ends mid-walk is truncated
        fin_st = (n_ph != iote_pkg::PH_DONE) ? iote_pkg::ST_BAD : n_st;

        o_res.valid      = i_accept & i_beat.last_item;
        o_res.beat.parse_status = (i_beat.protocol_number != iote_pkg::PROTO_UDP) ?
                                  iote_pkg::ST_NOTUDP : fin_st;
        o_res.beat.captured_option = (o_res.beat.parse_status == iote_pkg::ST_CAPT) ?
                                     n_cap : 64'd0;
        o_res.beat.packet_source_address      = i_beat.source_address;
        o_res.beat.packet_destination_address = i_beat.destination_address;
        o_res.beat.packet_source_port         = i_beat.source_port;
        o_res.beat.packet_destination_port    = i_beat.destination_port;

        if (i_beat.last_item) begin
            n_st  = fin_st;
            n_ph  = iote_pkg::PH_DONE;
            n_abl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= iote_pkg::PH_TYPE;
            r_st    <= iote_pkg::ST_NONE;
            r_abl   <= '0;
            r_obl   <= '0;
            r_cpos  <= '0;
            r_cap   <= '0;
            r_ctype <= '0;
        end else if (i_accept) begin
            r_ph    <= n_ph;
            r_st    <= n_st;
            r_abl   <= n_abl;
            r_obl   <= n_obl;
            r_cpos  <= n_cpos;
            r_cap   <= n_cap;
            r_ctype <= n_ctype;
        end
    end

endmodule

>>> src/iote_out_reg.sv
// Result register holding one packet result until taken downstream.
module iote_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iote_pkg::t_walk_res i_res,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output iote_pkg::t_out_beat o_out
);

    logic                r_valid;
    iote_pkg::t_out_beat r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_beat <= i_res.beat;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_beat;

endmodule

>>> src/ip_option_tlv_extractor_unit.sv
// IPv4 option TLV extractor: one options byte per beat, one result per packet.
// The result is registered and appears in the cycle after the packet's last beat is accepted.
// Throughput: 1 beat per cycle unless the input stalls; the walk state advances in a single pass per beat.
// Input stalls only on a last beat while the previous result is held stalled.
// Reset (synchronous, active low): walk idle, no result pending, code 31, length 8.
module ip_option_tlv_extractor_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  iote_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output iote_pkg::t_out_beat o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    iote_pkg::t_cfg      r_cfg;
    iote_pkg::t_walk_res walk_res;
    logic                in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code   <= 8'd31;
            r_cfg.length <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iote_pkg::CFG_CODE: r_cfg.code   <= i_cfg_data;
                iote_pkg::CFG_LEN:  r_cfg.length <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // only a result-producing beat has to wait for the result register
    assign o_in_stall = o_out_valid & i_out_stall & i_in.last_item;
    assign in_accept  = i_in_valid & ~o_in_stall;

    iote_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_beat   (i_in),
        .i_cfg    (r_cfg),
        .o_res    (walk_res)
    );

    iote_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (walk_res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.last_item) |=> o_out_valid)
        else $error("no result after accepted last beat");

    a_capture_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.parse_status != iote_pkg::ST_CAPT) |->
        (o_out.captured_option == 64'd0))
        else $error("captured bytes without capture status");

    a_not_udp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.last_item && i_in.protocol_number != iote_pkg::PROTO_UDP) |=>
        (o_out.parse_status == iote_pkg::ST_NOTUDP))
        else $error("non-UDP packet without not-UDP status");

endmodule
